>>> hw/rtl/dbz_indexed_trapezoid_interest_macros.svh
// Assertion macros for the reflectivity-indexed trapezoid interest block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DBZ_INDEXED_TRAPEZOID_INTEREST_MACROS_SVH
`define DBZ_INDEXED_TRAPEZOID_INTEREST_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, masked while reset is asserted.
`define DITRAP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// Checked property that must also hold during reset.
`define DITRAP_ASSERT_ALL(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define DITRAP_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define DITRAP_ASSERT_ALL(lbl, clk_s, prop, msg)
`endif
`endif

>>> hw/rtl/ditrap_pkg.sv
// Shared constants and types for the reflectivity-indexed trapezoid interest block.
// No dependencies; used by ditrap_shape and dbz_indexed_trapezoid_interest.
`default_nettype none

package ditrap_pkg;

    // Default shape table depth.
    localparam int unsigned TABLE_ENTRIES_DEF = 256;

    // Field widths fixed by the interface.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Full interest, 1.0 in Q1.15.
    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // Item commands.
    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_USE_TABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_WEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DBZ     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX  = 2'd3;

    // Configuration reset values.
    localparam logic        USE_TABLE_RST  = 1'b0;
    localparam logic [15:0] MAP_WEIGHT_RST = 16'd4096;
    localparam logic [11:0] MIN_DBZ_RST    = 12'hD80;   // -40.0 dBZ in Q8.4
    localparam logic [7:0]  LAST_INDEX_RST = 8'd139;

    // Stage enables handed from the sequencer to the shape evaluator.
    typedef struct packed {
        logic sel_en;
        logic mul_en;
        logic rnd_en;
    } shape_ctl_t;

endpackage : ditrap_pkg

`default_nettype wire

>>> hw/rtl/ditrap_shape.sv
// Trapezoid shape evaluator: segment select, ramp multiply and rounding stages.
// Depends on ditrap_pkg for the stage-enable struct and the 1.0 constant.
`default_nettype none

module ditrap_shape (
    input  wire logic                    clk,
    input  wire ditrap_pkg::shape_ctl_t  ctl,
    input  wire logic [63:0]             bp_word,
    input  wire logic [63:0]             slope_word,
    input  wire logic signed [15:0]      sample,
    output logic [15:0]                  interest
);
    import ditrap_pkg::*;

    typedef enum logic [1:0] {
        SEG_ZERO = 2'd0,
        SEG_FULL = 2'd1,
        SEG_RISE = 2'd2,
        SEG_FALL = 2'd3
    } seg_t;

    logic signed [15:0] x1, x2, x3, x4;
    logic signed [16:0] d_rise, d_fall;
    seg_t               seg_next;
    logic [15:0]        diff_next;
    logic [31:0]        slope_next;

    seg_t               seg_reg, seg2_reg;
    logic [15:0]        diff_reg;
    logic [31:0]        slope_reg;
    logic [47:0]        prod_reg;

    logic [48:0]        rnd_sum;
    logic [39:0]        ramp_val;
    logic [15:0]        ramp_cap;
    logic [15:0]        interest_next;
    logic [15:0]        interest_reg;

    assign x1 = $signed(bp_word[15:0]);
    assign x2 = $signed(bp_word[31:16]);
    assign x3 = $signed(bp_word[47:32]);
    assign x4 = $signed(bp_word[63:48]);

    // The sample lies above the ramp start on either ramp, so the
    // difference always fits in 16 unsigned bits.
    assign d_rise = {sample[15], sample} - {x1[15], x1};
    assign d_fall = {sample[15], sample} - {x3[15], x3};

    always_comb
    begin
        seg_next   = SEG_ZERO;
        diff_next  = d_rise[15:0];
        slope_next = slope_word[31:0];
        if (sample <= x1 || sample >= x4)
        begin
            seg_next = SEG_ZERO;
        end
        else if (sample >= x2 && sample <= x3)
        begin
            seg_next = SEG_FULL;
        end
        else if (sample >= x1 && sample <= x2)
        begin
            seg_next = SEG_RISE;
        end
        else if (sample >= x3 && sample <= x4)
        begin
            seg_next   = SEG_FALL;
            diff_next  = d_fall[15:0];
            slope_next = slope_word[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sel_en)
        begin
            seg_reg   <= seg_next;
            diff_reg  <= diff_next;
            slope_reg <= slope_next;
        end
        if (ctl.mul_en)
        begin
            seg2_reg <= seg_reg;
            prod_reg <= diff_reg * slope_reg;
        end
        if (ctl.rnd_en)
        begin
            interest_reg <= interest_next;
        end
    end

    // Round to Q1.15 and cap at full interest.
    assign rnd_sum  = {1'b0, prod_reg} + 49'd256;
    assign ramp_val = rnd_sum[48:9];
    assign ramp_cap = (ramp_val > 40'(ONE_Q15)) ? ONE_Q15 : ramp_val[15:0];

    always_comb
    begin
        case (seg2_reg)
            SEG_FULL: interest_next = ONE_Q15;
            SEG_RISE: interest_next = ramp_cap;
            SEG_FALL: interest_next = ONE_Q15 - ramp_cap;
            default:  interest_next = '0;
        endcase
    end

    assign interest = interest_reg;

endmodule : ditrap_shape

`default_nettype wire

>>> hw/rtl/dbz_indexed_trapezoid_interest.sv
// Top level of the reflectivity-indexed trapezoid interest map.
// Depends on ditrap_pkg, ditrap_shape and dbz_indexed_trapezoid_interest_macros.svh.
`default_nettype none
`include "dbz_indexed_trapezoid_interest_macros.svh"

// This block maps a feature sample to a fuzzy interest value through a
// trapezoid whose four breakpoints and two ramp slopes come from a shape
// table, then weights the interest and keeps saturating running sums of the
// weighted interest and of the weight. A write word stores one table entry
// (an entry index at or above TABLE_ENTRIES is dropped) and returns zero
// interest with the sums unchanged. An evaluate word picks entry zero, or,
// with use_table set, the entry round(dbz - table_min_dbz) clamped to zero,
// to table_last_index and to TABLE_ENTRIES - 1, and may clear both sums
// before it adds. The table lives in two single-port synchronous memories
// that come up undefined: every entry that an evaluate word can select must
// be written first. The block works on one word at a time. An evaluate word
// passes six register stages (memory read at the accepting edge, segment
// select, ramp multiply, rounding, weight multiply, accumulate); a write word
// goes from acceptance straight to the accumulate stage. A new input word is
// accepted in the cycle after the previous one has moved into the output
// register, even while that result is still stalled, so the block never takes
// a new word before the previous one is through. The sequencer steps the ramp
// multiplier and the weight multiplier through those stages.
module dbz_indexed_trapezoid_interest #(
    parameter int unsigned TABLE_ENTRIES = ditrap_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ditrap_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ditrap_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                command,
    input  wire logic [7:0]                          entry_index,
    input  wire logic signed [11:0]                  dbz,
    input  wire logic signed [15:0]                  sample_value,
    input  wire logic signed [15:0]                  bp_one,
    input  wire logic signed [15:0]                  bp_two,
    input  wire logic signed [15:0]                  bp_three,
    input  wire logic signed [15:0]                  bp_four,
    input  wire logic [31:0]                         rise_slope,
    input  wire logic [31:0]                         fall_slope,
    input  wire logic                                clear_sums,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [15:0]                              interest,
    output logic [18:0]                              weighted_interest,
    output logic [15:0]                              weight_out,
    output logic [31:0]                              sum_interest,
    output logic [31:0]                              sum_weight
);
    import ditrap_pkg::*;

    localparam int unsigned IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int unsigned LAST_ENTRY = TABLE_ENTRIES - 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEL  = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_RND  = 6'b001000,
        ST_WGT  = 6'b010000,
        ST_ACC  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;

    // Configuration registers.
    logic               use_table_reg;
    logic [15:0]        map_weight_reg;
    logic [11:0]        min_dbz_reg;
    logic [7:0]         last_index_reg;

    // Shape table memories.
    logic [63:0]        bp_mem    [TABLE_ENTRIES];
    logic [63:0]        slope_mem [TABLE_ENTRIES];
    logic [63:0]        bp_rd_reg;
    logic [63:0]        slope_rd_reg;

    // Per-word registers.
    logic               wr_reg;
    logic               clr_reg;
    logic signed [15:0] sample_reg;
    logic [18:0]        weighted_reg;

    // Running sums and output word.
    logic [31:0]        interest_sum_reg, interest_sum_next;
    logic [31:0]        weight_sum_reg, weight_sum_next;
    logic               out_valid_reg;
    logic [15:0]        interest_out_reg;
    logic [18:0]        weighted_out_reg;
    logic [15:0]        weight_out_reg;

    logic               in_acc;
    logic               out_free;
    logic               acc_load;
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [13:0]        dbz_off;
    logic               dbz_pos;
    logic [8:0]         idx_round;
    logic [7:0]         idx_cand;
    logic [31:0]        wprod;
    logic [15:0]        shape_interest;
    shape_ctl_t         shape_ctl;
    logic [31:0]        base_isum, base_wsum;
    logic [32:0]        isum_add, wsum_add;

    // ------------------------------------------------------------------
    // Configuration port. The user must issue writes only while the block is
    // idle; the block itself does not enforce it, and the port never pushes back.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_table_reg  <= USE_TABLE_RST;
            map_weight_reg <= MAP_WEIGHT_RST;
            min_dbz_reg    <= MIN_DBZ_RST;
            last_index_reg <= LAST_INDEX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_USE_TABLE:  use_table_reg  <= cfg_data[0];
                REG_MAP_WEIGHT: map_weight_reg <= cfg_data[15:0];
                REG_MIN_DBZ:    min_dbz_reg    <= cfg_data[11:0];
                REG_LAST_INDEX: last_index_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and table addressing.
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign wr_en    = in_acc && (command == CMD_WRITE) && (32'(entry_index) < TABLE_ENTRIES);
    assign rd_en    = in_acc && (command == CMD_EVAL);
    assign wr_idx   = IDX_W'(entry_index);

    // Entry index: round(dbz - min_dbz) with both in Q8.4, i.e. add half an
    // LSB of the index and drop the four fraction bits. Negative offsets
    // select entry zero.
    assign dbz_off   = {{2{dbz[11]}}, dbz} - {{2{min_dbz_reg[11]}}, min_dbz_reg} + 14'd8;
    assign dbz_pos   = !dbz_off[13] && (dbz_off != '0);
    assign idx_round = dbz_pos ? dbz_off[12:4] : 9'd0;
    assign idx_cand  = (idx_round > {1'b0, last_index_reg}) ? last_index_reg : idx_round[7:0];

    always_comb
    begin
        rd_idx = '0;
        if (use_table_reg)
        begin
            if (32'(idx_cand) > LAST_ENTRY)
            begin
                rd_idx = IDX_W'(LAST_ENTRY);
            end
            else
            begin
                rd_idx = IDX_W'(idx_cand);
            end
        end
    end

    // Only one word is in flight, so a table write and a later read of the
    // same entry can never overlap.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bp_mem[wr_idx]    <= {bp_four, bp_three, bp_two, bp_one};
            slope_mem[wr_idx] <= {fall_slope, rise_slope};
        end
        if (rd_en)
        begin
            bp_rd_reg    <= bp_mem[rd_idx];
            slope_rd_reg <= slope_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            wr_reg     <= (command == CMD_WRITE);
            clr_reg    <= clear_sums;
            sample_reg <= sample_value;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign acc_load = (state_reg == ST_ACC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (command == CMD_WRITE) ? ST_ACC : ST_SEL;
                end
            end
            ST_SEL: state_next = ST_MUL;
            ST_MUL: state_next = ST_RND;
            ST_RND: state_next = ST_WGT;
            ST_WGT: state_next = ST_ACC;
            ST_ACC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Shape evaluation and weighting.
    // ------------------------------------------------------------------
    assign shape_ctl.sel_en = (state_reg == ST_SEL);
    assign shape_ctl.mul_en = (state_reg == ST_MUL);
    assign shape_ctl.rnd_en = (state_reg == ST_RND);

    ditrap_shape u_shape (
        .clk        (clk),
        .ctl        (shape_ctl),
        .bp_word    (bp_rd_reg),
        .slope_word (slope_rd_reg),
        .sample     (sample_reg),
        .interest   (shape_interest)
    );

    // Interest is at most 1.0, so the Q4.15 product fits in 19 bits.
    assign wprod = shape_interest * map_weight_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WGT)
        begin
            weighted_reg <= wprod[30:12];
        end
    end

    // ------------------------------------------------------------------
    // Running sums for evaluate words: clear first, add weighted interest
    // only for nonzero interest, always add the weight, saturate at all ones.
    // ------------------------------------------------------------------
    assign base_isum = clr_reg ? '0 : interest_sum_reg;
    assign base_wsum = clr_reg ? '0 : weight_sum_reg;
    assign isum_add  = {1'b0, base_isum} + 33'(weighted_reg);
    assign wsum_add  = {1'b0, base_wsum} + 33'(map_weight_reg);

    always_comb
    begin
        interest_sum_next = interest_sum_reg;
        weight_sum_next   = weight_sum_reg;
        if (!wr_reg)
        begin
            if (shape_interest != '0)
            begin
                interest_sum_next = isum_add[32] ? '1 : isum_add[31:0];
            end
            else
            begin
                interest_sum_next = base_isum;
            end
            weight_sum_next = wsum_add[32] ? '1 : wsum_add[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interest_sum_reg <= '0;
            weight_sum_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (acc_load)
            begin
                interest_sum_reg <= interest_sum_next;
                weight_sum_reg   <= weight_sum_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_load)
        begin
            interest_out_reg <= wr_reg ? '0 : shape_interest;
            weighted_out_reg <= wr_reg ? '0 : weighted_reg;
            weight_out_reg   <= map_weight_reg;
        end
    end

    // The sum registers only change when a new word enters the output
    // register, so they double as the output fields.
    assign out_valid         = out_valid_reg;
    assign interest          = interest_out_reg;
    assign weighted_interest = weighted_out_reg;
    assign weight_out        = weight_out_reg;
    assign sum_interest      = interest_sum_reg;
    assign sum_weight        = weight_sum_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `DITRAP_ASSERT(a_eval_starts_select, clk, rst_n, (in_acc && command == CMD_EVAL) |=> (state_reg == ST_SEL), "evaluate word did not start the table read path")
    `DITRAP_ASSERT(a_write_keeps_sums, clk, rst_n, (acc_load && wr_reg) |=> ($stable(interest_sum_reg) && $stable(weight_sum_reg)), "write word changed the running sums")
    `DITRAP_ASSERT(a_isum_monotonic, clk, rst_n, (acc_load && !wr_reg && !clr_reg) |=> (interest_sum_reg >= $past(interest_sum_reg)), "interest sum decreased without a clear")
    `DITRAP_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_reg && out_stall) |-> !acc_load, "result overwritten while stalled")
    `DITRAP_ASSERT_ALL(a_interest_bound, clk, (!out_valid_reg || interest_out_reg <= ONE_Q15), "interest above 1.0")

endmodule : dbz_indexed_trapezoid_interest

`default_nettype wire

>>> tb/tb_dbz_indexed_trapezoid_interest.sv
// Self-checking testbench for the reflectivity-indexed trapezoid interest block.
// Depends on ditrap_pkg and on the dbz_indexed_trapezoid_interest RTL.
`timescale 1ns / 100ps

// Testbench structure
// -------------------
// Input words go in through a single send task. At the clock edge where a word
// is accepted, that task runs it through a local copy of the block's behavior:
// shape table, running sums and configuration. It then queues the expected
// result. A checker process compares every accepted result word with the oldest
// queued expectation.
// A separate process drives out_stall. It holds off at random after each result.
// It can also hold off for one long stretch, so that the block fills up and
// stalls its input.
// A watchdog ends the run if no handshake of any kind completes for too long.
// Evaluate words may only select table entries that were written before. Every
// random evaluate therefore loads its entry first if that entry is still empty.
module tb_dbz_indexed_trapezoid_interest;
    import ditrap_pkg::*;

    localparam int ENTRIES        = 256;
    localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles tolerated, well above SLOW_STALL
    localparam int SLOW_STALL     = 150;    // long receiver hold-off, in cycles
    localparam int BURST_WORDS    = 40;     // full-weight words sent back to back

    // One input word, with the block's field widths.
    typedef struct packed {
        logic               cmd;
        logic [7:0]         entry;
        logic signed [11:0] dbz;
        logic signed [15:0] feature;
        logic signed [15:0] x1;
        logic signed [15:0] x2;
        logic signed [15:0] x3;
        logic signed [15:0] x4;
        logic [31:0]        rise;
        logic [31:0]        fall;
        logic               clear;
    } gate_word_t;

    // One result word.
    typedef struct packed {
        logic [15:0] interest;
        logic [18:0] weighted;
        logic [15:0] weight;
        logic [31:0] sum_i;
        logic [31:0] sum_w;
    } interest_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic [7:0]         entry_index;
    logic signed [11:0] dbz;
    logic signed [15:0] sample_value;
    logic signed [15:0] bp_one;
    logic signed [15:0] bp_two;
    logic signed [15:0] bp_three;
    logic signed [15:0] bp_four;
    logic [31:0]        rise_slope;
    logic [31:0]        fall_slope;
    logic               clear_sums;

    logic        out_valid;
    logic        out_stall;
    logic [15:0] interest;
    logic [18:0] weighted_interest;
    logic [15:0] weight_out;
    logic [31:0] sum_interest;
    logic [31:0] sum_weight;

    // Local copy of the block's state and configuration.
    gate_word_t         shape_store [ENTRIES];
    bit                 shape_loaded [ENTRIES];
    logic [31:0]        run_interest_sum;
    logic [31:0]        run_weight_sum;
    logic               cur_use_table;
    logic [15:0]        cur_weight;
    logic signed [11:0] cur_min_dbz;
    logic [7:0]         cur_last_index;

    interest_result_t pending_results[$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  stall_left     = 0;
    int  hold_off_left  = 0;
    bit  gaps_on        = 1'b1;

    always #5 clk = ~clk;

    dbz_indexed_trapezoid_interest #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .entry_index       (entry_index),
        .dbz               (dbz),
        .sample_value      (sample_value),
        .bp_one            (bp_one),
        .bp_two            (bp_two),
        .bp_three          (bp_three),
        .bp_four           (bp_four),
        .rise_slope        (rise_slope),
        .fall_slope        (fall_slope),
        .clear_sums        (clear_sums),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .interest          (interest),
        .weighted_interest (weighted_interest),
        .weight_out        (weight_out),
        .sum_interest      (sum_interest),
        .sum_weight        (sum_weight)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int clip16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int clip12(int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    // The table entry is round(dbz - min_dbz) in Q8.4. It clamps at zero and
    // at the programmed last index. Without table mode it is always entry zero.
    function automatic int selected_entry(logic signed [11:0] d);
        int t;
        int e;
        e = 0;
        if (cur_use_table) begin
            t = int'(d) - int'(cur_min_dbz) + 8;
            if (t > 0)
                e = t >>> 4;
            if (e > int'(cur_last_index))
                e = int'(cur_last_index);
            if (e > ENTRIES - 1)
                e = ENTRIES - 1;
        end
        return e;
    endfunction

    // The ramp height is the offset times the Q8.24 slope. It is rounded to
    // Q1.15 and capped at full interest.
    function automatic logic [15:0] ramp_height(int diff, logic [31:0] slope);
        logic [63:0] p;
        p = (64'(diff) * 64'(slope) + 64'd256) >> 9;
        return (p > 64'd32768) ? ONE_Q15 : p[15:0];
    endfunction

    function automatic logic [15:0] trapezoid(int v, gate_word_t s);
        int x1;
        int x2;
        int x3;
        int x4;
        x1 = int'(s.x1);
        x2 = int'(s.x2);
        x3 = int'(s.x3);
        x4 = int'(s.x4);
        if (v <= x1 || v >= x4)
            return 16'd0;
        if (v >= x2 && v <= x3)
            return ONE_Q15;
        if (v >= x1 && v <= x2)
            return ramp_height(v - x1, s.rise);
        if (v >= x3 && v <= x4)
            return 16'(32768 - int'(ramp_height(v - x3, s.fall)));
        return 16'd0;
    endfunction

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Applies one accepted word to the local state and returns its result.
    function automatic interest_result_t predict_gate(gate_word_t w);
        interest_result_t r;
        int               e;
        logic [34:0]      prod;
        r = '0;
        r.weight = cur_weight;
        if (w.cmd == CMD_WRITE) begin
            shape_store[w.entry]  = w;
            shape_loaded[w.entry] = 1'b1;
        end else begin
            e = selected_entry(w.dbz);
            r.interest = trapezoid(int'(w.feature), shape_store[e]);
            prod = 35'(r.interest) * 35'(cur_weight);
            r.weighted = prod[30:12];
            if (w.clear) begin
                run_interest_sum = '0;
                run_weight_sum   = '0;
            end
            // A zero interest leaves the interest sum alone; the weight always counts.
            if (r.interest != 16'd0)
                run_interest_sum = sat_add32(run_interest_sum, 32'(r.weighted));
            run_weight_sum = sat_add32(run_weight_sum, 32'(cur_weight));
        end
        r.sum_i = run_interest_sum;
        r.sum_w = run_weight_sum;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------

    // Fields that a word does not use carry random values, so that every
    // input bit toggles during the run.
    function automatic gate_word_t filler_word();
        gate_word_t w;
        w.cmd     = CMD_EVAL;
        w.entry   = 8'($urandom);
        w.dbz     = 12'($urandom);
        w.feature = 16'($urandom);
        w.x1      = 16'($urandom);
        w.x2      = 16'($urandom);
        w.x3      = 16'($urandom);
        w.x4      = 16'($urandom);
        w.rise    = $urandom;
        w.fall    = $urandom;
        w.clear   = 1'($urandom);
        return w;
    endfunction

    function automatic gate_word_t shape_word(logic [7:0] e, int x1, int x2, int x3, int x4,
                                              logic [31:0] rise, logic [31:0] fall);
        gate_word_t w;
        w       = filler_word();
        w.cmd   = CMD_WRITE;
        w.entry = e;
        w.x1    = 16'(x1);
        w.x2    = 16'(x2);
        w.x3    = 16'(x3);
        w.x4    = 16'(x4);
        w.rise  = rise;
        w.fall  = fall;
        return w;
    endfunction

    function automatic gate_word_t eval_word(int d, int v, bit clear);
        gate_word_t w;
        w         = filler_word();
        w.cmd     = CMD_EVAL;
        w.dbz     = 12'(d);
        w.feature = 16'(v);
        w.clear   = clear;
        return w;
    endfunction

    // Most shapes are ordered breakpoints with matching reciprocal slopes.
    // The rest are arbitrary breakpoints and slopes.
    function automatic gate_word_t random_shape(logic [7:0] e);
        int x [4];
        int span;
        int d1;
        int d3;
        logic [31:0] rise;
        logic [31:0] fall;
        if ($urandom_range(0, 9) < 8) begin
            span = 1 << $urandom_range(0, 13);
            x[0] = int'($urandom_range(0, 65535)) - 32768;
            for (int k = 1; k < 4; k++)
                x[k] = clip16(x[k-1] + int'($urandom_range(0, span)));
            d1 = x[1] - x[0];
            d3 = x[3] - x[2];
            rise = (d1 == 0) ? $urandom : 32'((16777216 + d1 / 2) / d1);
            fall = (d3 == 0) ? $urandom : 32'((16777216 + d3 / 2) / d3);
            if ($urandom_range(0, 7) == 0)
                rise = rise + $urandom_range(0, 4095);
        end else begin
            for (int k = 0; k < 4; k++)
                x[k] = int'($urandom_range(0, 65535)) - 32768;
            rise = $urandom;
            fall = $urandom;
        end
        return shape_word(e, x[0], x[1], x[2], x[3], rise, fall);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one word and waits for its acceptance. in_valid stays high
    // afterwards, so a following word with no gap goes back to back.
    task automatic send_word(input gate_word_t w);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 4)) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        command      = w.cmd;
        entry_index  = w.entry;
        dbz          = w.dbz;
        sample_value = w.feature;
        bp_one       = w.x1;
        bp_two       = w.x2;
        bp_three     = w.x3;
        bp_four      = w.x4;
        rise_slope   = w.rise;
        fall_slope   = w.fall;
        clear_sums   = w.clear;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.insert(pending_results.size(), predict_gate(w));
    endtask

    // Loads the selected entry first if it was never written, so that no
    // evaluate reads an undefined table entry.
    task automatic send_eval(input gate_word_t w);
        int e;
        e = selected_entry(w.dbz);
        if (!shape_loaded[e])
            send_word(random_shape(8'(e)));
        send_word(w);
    endtask

    // A random evaluate. In table mode its reflectivity mostly lands inside one entry's
    // span, and its sample mostly lands near one of the selected shape's breakpoints.
    task automatic send_random_eval();
        gate_word_t w;
        int         e;
        int         pick;
        int         lo;
        int         hi;
        w = eval_word(0, 0, ($urandom_range(0, 19) == 0));
        if (cur_use_table && $urandom_range(0, 4) != 0)
            w.dbz = 12'(clip12(int'(cur_min_dbz)
                               + 16 * int'($urandom_range(0, int'(cur_last_index) + 3))
                               + int'($urandom_range(0, 15)) - 8));
        else
            w.dbz = 12'($urandom);
        e = selected_entry(w.dbz);
        if (!shape_loaded[e])
            send_word(random_shape(8'(e)));
        pick = $urandom_range(0, 9);
        lo   = int'(shape_store[e].x1);
        hi   = int'(shape_store[e].x4);
        if (pick < 7) begin
            case ($urandom_range(0, 3))
                0:       lo = int'(shape_store[e].x1);
                1:       lo = int'(shape_store[e].x2);
                2:       lo = int'(shape_store[e].x3);
                default: lo = int'(shape_store[e].x4);
            endcase
            w.feature = 16'(clip16(lo + int'($urandom_range(0, 24)) - 12));
        end else if (pick < 8 && hi > lo) begin
            w.feature = 16'(lo + int'($urandom_range(0, hi - lo)));
        end else begin
            w.feature = 16'($urandom);
        end
        send_word(w);
    endtask

    task automatic send_random_word();
        if ($urandom_range(0, 4) == 0)
            send_word(random_shape(8'($urandom)));
        else
            send_random_eval();
    endtask

    // Stops offering input and waits until every expected result has come.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register writes are only made with the block idle, so drain first.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_USE_TABLE:  cur_use_table  = data[0];
            REG_MAP_WEIGHT: cur_weight     = data;
            REG_MIN_DBZ:    cur_min_dbz    = data[11:0];
            REG_LAST_INDEX: cur_last_index = data[7:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input bit use_tbl, input logic [15:0] wgt,
                              input logic signed [11:0] min_dbz, input logic [7:0] last);
        write_reg(REG_USE_TABLE, 16'(use_tbl));
        write_reg(REG_MAP_WEIGHT, wgt);
        write_reg(REG_MIN_DBZ, {{4{min_dbz[11]}}, min_dbz});
        write_reg(REG_LAST_INDEX, 16'(last));
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------

    always @(posedge clk) begin : result_check
        interest_result_t got;
        interest_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            got.interest = interest;
            got.weighted = weighted_interest;
            got.weight   = weight_out;
            got.sum_i    = sum_interest;
            got.sum_w    = sum_weight;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result word with nothing expected: interest=%0d sum_i=%0d",
                             got.interest, got.sum_i);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: result mismatch at %0t", $realtime);
                        $display("  interest exp=%0d got=%0d  weighted exp=%0d got=%0d",
                                 want.interest, got.interest, want.weighted, got.weighted);
                        $display("  weight exp=%0d got=%0d", want.weight, got.weight);
                        $display("  sum_interest exp=%0d got=%0d  sum_weight exp=%0d got=%0d",
                                 want.sum_i, got.sum_i, want.sum_w, got.sum_w);
                    end
                end
            end
            stall_left = gaps_on ? int'($urandom_range(0, 4)) : 0;
        end
    end

    // A long hold-off takes priority over the short per-result stalls.
    always @(negedge clk) begin
        if (hold_off_left > 0) begin
            out_stall = 1'b1;
            hold_off_left--;
        end else if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL dbz_indexed_trapezoid_interest");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The reset configuration uses entry zero with unit weight. A unit trapezoid
    // is probed at, between and beyond its breakpoints. A write word that sets clear
    // must leave the sums alone.
    task automatic test_reset_defaults();
        gate_word_t w;
        send_word(shape_word(8'd0, -256, 0, 256, 512, 32'd65536, 32'd65536));
        send_eval(eval_word(0, -300, 1'b1));
        send_eval(eval_word(0, -256, 1'b0));
        send_eval(eval_word(0, -128, 1'b0));
        send_eval(eval_word(0, 0, 1'b0));
        send_eval(eval_word(0, 256, 1'b0));
        w = shape_word(8'd0, -256, 0, 256, 512, 32'd65536, 32'd65536);
        w.clear = 1'b1;
        send_word(w);
        send_eval(eval_word(0, 384, 1'b0));
        send_eval(eval_word(0, 512, 1'b0));
        send_eval(eval_word(0, 600, 1'b0));
    endtask

    // This test covers full-scale breakpoints, capped ramps, and a steep fall.
    // The steep fall gives zero interest inside the open span.
    task automatic test_field_extremes();
        send_word(shape_word(8'd0, -32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_eval(eval_word(-2048, -32768, 1'b0));
        send_eval(eval_word(2047, 32767, 1'b0));
        send_eval(eval_word(0, -32767, 1'b0));
        send_word(shape_word(8'd0, 0, 1000, 1000, 2000, 32'hFFFF_FFFF, 32'd0));
        send_eval(eval_word(0, 1, 1'b0));
        send_eval(eval_word(0, 1500, 1'b0));
        send_word(shape_word(8'd0, 0, 0, 0, 2000, 32'd0, 32'hFFFF_FFFF));
        send_eval(eval_word(0, 1, 1'b0));
    endtask

    task automatic test_weight_extremes();
        send_word(shape_word(8'd0, -256, 0, 256, 512, 32'd65536, 32'd65536));
        write_reg(REG_MAP_WEIGHT, 16'd0);
        send_eval(eval_word(0, 100, 1'b0));
        write_reg(REG_MAP_WEIGHT, 16'hFFFF);
        send_eval(eval_word(0, 100, 1'b1));
        send_eval(eval_word(0, -128, 1'b0));
    endtask

    // The entry index rounds, clamps at zero and clamps at the last index.
    task automatic test_entry_select();
        set_config(1'b1, 16'd4096, -12'sd640, 8'd139);
        send_eval(eval_word(-2048, 0, 1'b0));
        send_eval(eval_word(-640 + 7, 0, 1'b0));
        send_eval(eval_word(-640 + 8, 0, 1'b0));
        send_eval(eval_word(-640 + 16 * 139, 0, 1'b0));
        send_eval(eval_word(2047, 0, 1'b0));
        write_reg(REG_LAST_INDEX, 16'd0);
        send_eval(eval_word(2047, 0, 1'b0));
    endtask

    // Full interest at the largest weight, sent back to back. A clearing word
    // opens the burst and another ends it; in between, both running sums grow by
    // their largest step on every word.
    task automatic test_full_weight_burst();
        set_config(1'b0, 16'hFFFF, -12'sd640, 8'd139);
        send_word(shape_word(8'd0, -256, 0, 256, 512, 32'd65536, 32'd65536));
        gaps_on = 1'b0;
        send_word(eval_word(0, 100, 1'b1));
        for (int n = 0; n < BURST_WORDS; n++)
            send_word(eval_word(0, 100, 1'b0));
        send_word(eval_word(0, 100, 1'b1));
        gaps_on = 1'b1;
        drain();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the
    // block fills up and stalls its input.
    task automatic test_output_hold();
        set_config(1'b1, 16'd4096, -12'sd640, 8'd139);
        @(posedge clk);
        hold_off_left = SLOW_STALL;
        repeat (40) send_random_word();
    endtask

    // The sender pauses until every expected result has come, then resumes.
    task automatic test_drain_pause();
        repeat (30) send_random_word();
        drain();
        repeat (30) send_random_word();
    endtask

    // Random words under several configurations, including the extremes.
    // One phase runs half its words with no gaps on either side.
    task automatic test_random_phases();
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: set_config(1'b0, 16'd4096, -12'sd640, 8'd139);
                1: set_config(1'b1, 16'd4096, -12'sd640, 8'd139);
                2: set_config(1'b1, 16'hFFFF, -12'sd2048, 8'd255);
                3: set_config(1'b1, 16'd0, 12'sd2047, 8'd0);
                4: set_config(1'b1, 16'($urandom), 12'($urandom), 8'($urandom));
                5: set_config(1'b0, 16'hFFFF, 12'($urandom), 8'($urandom));
                default: set_config(1'b1, 16'($urandom), 12'($urandom), 8'd255);
            endcase
            if (p == 4)
                gaps_on = 1'b0;
            for (int n = 0; n < 220; n++) begin
                if (n == 110)
                    gaps_on = 1'b1;
                send_random_word();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        command          = CMD_EVAL;
        entry_index      = '0;
        dbz              = '0;
        sample_value     = '0;
        bp_one           = '0;
        bp_two           = '0;
        bp_three         = '0;
        bp_four          = '0;
        rise_slope       = '0;
        fall_slope       = '0;
        clear_sums       = 1'b0;
        out_stall        = 1'b0;
        run_interest_sum = '0;
        run_weight_sum   = '0;
        cur_use_table    = USE_TABLE_RST;
        cur_weight       = MAP_WEIGHT_RST;
        cur_min_dbz      = MIN_DBZ_RST;
        cur_last_index   = LAST_INDEX_RST;
        for (int k = 0; k < ENTRIES; k++)
            shape_loaded[k] = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_weight_extremes();
        test_entry_select();
        test_full_weight_burst();
        test_output_hold();
        test_drain_pause();
        test_random_phases();

        // Let the last results through, then keep the clock running so that
        // anything stray can still show up at the output.
        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS dbz_indexed_trapezoid_interest");
        else
            $display("FAIL dbz_indexed_trapezoid_interest");
        $finish;
    end

endmodule
